// ===== rtl/core/bre_pkg.sv =====
package bre_pkg;

  localparam int BLOCK_BYTES = 256;
  localparam int MAX_RUN     = 255;

  localparam int BYTE_W   = 8;
  localparam int RUN_W    = 8;
  localparam int SIZE_W   = 16;
  localparam int PAIR_W   = RUN_W + BYTE_W;
  localparam int PAIR_AW  = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int PTOTAL_W = $clog2(BLOCK_BYTES + 1);
  localparam int FILL_W   = PTOTAL_W;
  localparam int DRAIN_W  = PTOTAL_W + 1;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_CLOSE  = 2'd1,
    CMD_PULL   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_TAKEN  = 3'd0,
    ST_CLOSED = 3'd1,
    ST_GIVEN  = 3'd2,
    ST_BUSY   = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [BYTE_W-1:0]   data;
    logic                last;
  } result_t;

  typedef struct packed {
    logic                en;
    logic [PAIR_AW-1:0]  addr;
    logic [PAIR_W-1:0]   data;
  } mem_wr_t;

endpackage

// ===== rtl/core/block_rle_encoder.sv =====
// Block run-length encoder.
// Input channel (in_valid/in_ready) carries one command item: command and
// data_byte. Append commands gather bytes into runs of at most 255 equal
// bytes; a block closes after 256 bytes or on an append-and-close item.
// Pull commands drain a closed block one byte per item: a 16-bit big-endian
// size (twice the pair count), then count,symbol pairs, the final symbol
// byte flagged by last_of_block. Appends during a drain return busy.
// Output channel (out_valid/out_ready) returns exactly one result item per
// input item: status, out_byte, last_of_block.
// A result passes from the input register to the result register before it
// is valid on the output, where it can be taken.
// Throughput: one item per cycle while out_ready is high, set by the single pass
// from input register to result register; the pair store is read ahead of the pull.
// Reset (rst, synchronous): no open run, empty block, nothing to drain,
// both registers empty. The pair store is not cleared.
// When out_ready is low the result register holds; in_ready stays high
// until the input register is also full, so one more item is taken.
module block_rle_encoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic [bre_pkg::BYTE_W-1:0]  data_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  status,
  output logic [bre_pkg::BYTE_W-1:0]  out_byte,
  output logic                        last_of_block
);
  import bre_pkg::*;

  logic               iv;
  logic [1:0]         icmd;
  logic [BYTE_W-1:0]  ibyte;
  logic               process;
  result_t            eng_res;
  result_t            ores;
  mem_wr_t            mem_wr;
  logic [PAIR_AW-1:0] rd_addr;
  logic [PAIR_W-1:0]  rd_data;

  assign process  = iv && (!out_valid || out_ready);
  assign in_ready = !iv || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        iv <= 1'b1;
      end else if (process) begin
        iv <= 1'b0;
      end
      if (process) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      icmd  <= command;
      ibyte <= data_byte;
    end
    if (process) begin
      ores <= eng_res;
    end
  end

  bre_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .fire    (process),
    .cmd     (icmd),
    .byte_in (ibyte),
    .res     (eng_res),
    .mem_wr  (mem_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bre_pair_ram u_ram (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign status        = ores.status;
  assign out_byte      = ores.data;
  assign last_of_block = ores.last;

endmodule

// ===== rtl/core/bre_pair_ram.sv =====
module bre_pair_ram (
  input  logic                         clk,
  input  bre_pkg::mem_wr_t             wr,
  input  logic [bre_pkg::PAIR_AW-1:0]  rd_addr,
  output logic [bre_pkg::PAIR_W-1:0]   rd_data
);
  import bre_pkg::*;

  logic [PAIR_W-1:0] mem [BLOCK_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/bre_engine.sv =====
module bre_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [1:0]                   cmd,
  input  logic [bre_pkg::BYTE_W-1:0]   byte_in,
  output bre_pkg::result_t             res,
  output bre_pkg::mem_wr_t             mem_wr,
  output logic [bre_pkg::PAIR_AW-1:0]  rd_addr,
  input  logic [bre_pkg::PAIR_W-1:0]   rd_data
);
  import bre_pkg::*;

  logic [BYTE_W-1:0]   run_symbol, run_symbol_next;
  logic [RUN_W-1:0]    run_length, run_length_next;
  logic [FILL_W-1:0]   block_fill, block_fill_next;
  logic [PTOTAL_W-1:0] pair_total, pair_total_next;
  logic                block_ready, block_ready_next;
  logic [DRAIN_W-1:0]  drain_index, drain_index_next;
  logic                pend_valid, pend_valid_next;
  logic [PAIR_AW-1:0]  pend_addr, pend_addr_next;
  logic [PAIR_W-1:0]   pend_data, pend_data_next;

  logic                app_wr_en;
  logic [PAIR_AW-1:0]  app_wr_addr;
  logic [PAIR_W-1:0]   app_wr_data;

  logic                is_append;
  logic                extend;
  logic [PTOTAL_W-1:0] pt;
  logic [RUN_W-1:0]    len_n;
  logic [BYTE_W-1:0]   sym_n;
  logic [FILL_W-1:0]   fill_inc;
  logic [SIZE_W-1:0]   size;
  logic [DRAIN_W-1:0]  last_pos;

  assign size     = SIZE_W'({pair_total, 1'b0});
  assign last_pos = {pair_total, 1'b1};

  always_comb begin
    run_symbol_next  = run_symbol;
    run_length_next  = run_length;
    block_fill_next  = block_fill;
    pair_total_next  = pair_total;
    block_ready_next = block_ready;
    drain_index_next = drain_index;
    pend_valid_next  = 1'b0;
    pend_addr_next   = pend_addr;
    pend_data_next   = pend_data;
    app_wr_en        = 1'b0;
    app_wr_addr      = pair_total[PAIR_AW-1:0];
    app_wr_data      = {run_length, run_symbol};
    res              = '{status: ST_EMPTY, data: '0, last: 1'b0};
    is_append        = cmd inside {CMD_APPEND, CMD_CLOSE};
    extend           = (run_length != '0) && (byte_in == run_symbol) &&
                       (run_length < RUN_W'(MAX_RUN));
    pt               = pair_total;
    len_n            = run_length + 1'b1;
    sym_n            = run_symbol;
    fill_inc         = block_fill + 1'b1;

    if (fire) begin
      if (is_append) begin
        if (block_ready) begin
          res.status = ST_BUSY;
        end else begin
          if (!extend) begin
            if (run_length != '0) begin
              app_wr_en = 1'b1;
              pt        = pair_total + 1'b1;
            end
            sym_n = byte_in;
            len_n = RUN_W'(1);
          end
          if (fill_inc == FILL_W'(BLOCK_BYTES) || cmd == CMD_CLOSE) begin
            // final run is written to the store from the pend registers in the following cycle
            pend_valid_next  = 1'b1;
            pend_addr_next   = pt[PAIR_AW-1:0];
            pend_data_next   = {len_n, sym_n};
            pair_total_next  = pt + 1'b1;
            run_symbol_next  = sym_n;
            run_length_next  = '0;
            block_fill_next  = '0;
            block_ready_next = 1'b1;
            drain_index_next = '0;
            res.status       = ST_CLOSED;
          end else begin
            pair_total_next  = pt;
            run_symbol_next  = sym_n;
            run_length_next  = len_n;
            block_fill_next  = fill_inc;
            res.status       = ST_TAKEN;
          end
        end
      end else if (cmd == CMD_PULL && block_ready) begin
        res.status = ST_GIVEN;
        if (drain_index == '0) begin
          res.data = size[SIZE_W-1:BYTE_W];
        end else if (drain_index == DRAIN_W'(1)) begin
          res.data = size[BYTE_W-1:0];
        end else if (!drain_index[0]) begin
          res.data = rd_data[PAIR_W-1:BYTE_W];
        end else begin
          res.data = rd_data[BYTE_W-1:0];
        end
        if (drain_index == last_pos) begin
          res.last         = 1'b1;
          block_ready_next = 1'b0;
          pair_total_next  = '0;
          drain_index_next = '0;
        end else begin
          drain_index_next = drain_index + 1'b1;
        end
      end
    end
  end

  // read data tracks the pair that the next pull needs
  assign rd_addr = PAIR_AW'(drain_index_next[DRAIN_W-1:1] - 1'b1);

  always_comb begin
    if (pend_valid) begin
      mem_wr = '{en: 1'b1, addr: pend_addr, data: pend_data};
    end else begin
      mem_wr = '{en: app_wr_en, addr: app_wr_addr, data: app_wr_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_symbol  <= '0;
      run_length  <= '0;
      block_fill  <= '0;
      pair_total  <= '0;
      block_ready <= 1'b0;
      drain_index <= '0;
      pend_valid  <= 1'b0;
    end else begin
      run_symbol  <= run_symbol_next;
      run_length  <= run_length_next;
      block_fill  <= block_fill_next;
      pair_total  <= pair_total_next;
      block_ready <= block_ready_next;
      drain_index <= drain_index_next;
      pend_valid  <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= pend_addr_next;
    pend_data <= pend_data_next;
  end

`ifndef NO_ASSERTIONS
  a_pend_no_clash: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !app_wr_en)
    else $error("pending pair write collides with run write");

  a_pend_single: assert property (@(posedge clk) disable iff (rst)
    pend_valid |=> !pend_valid)
    else $error("pending pair write held more than one cycle");

  a_close_sets_pend: assert property (@(posedge clk) disable iff (rst)
    (fire && res.status == ST_CLOSED) |=> (pend_valid && block_ready))
    else $error("block close did not queue final pair");

  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    !block_ready |-> (drain_index == '0))
    else $error("drain index moved without a closed block");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    block_ready |-> (drain_index <= last_pos))
    else $error("drain index ran past end of block");
`endif

endmodule
